// ===== rtl/afs_pkg.sv =====
`default_nettype none

package afs_pkg;

    // Margin applied around the stick limits when checking the arm/disarm gesture.
    localparam int unsigned GestureMargin = 150;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE_DEAD_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_STICK_MIN           = 3'd1;
    localparam logic [2:0] REG_STICK_MAX           = 3'd2;
    localparam logic [2:0] REG_HOLD_TIME_MS        = 3'd3;
    localparam logic [2:0] REG_LOST_LIMIT_MS       = 3'd4;
    localparam logic [2:0] REG_MODE_DEBOUNCE_TICKS = 3'd5;
    localparam logic [2:0] REG_LOW_BATTERY_MV      = 3'd6;

    // Configuration reset values.
    localparam logic [11:0] MODE_DEAD_THRESHOLD_RST = 12'd1500;
    localparam logic [11:0] STICK_MIN_RST           = 12'd1000;
    localparam logic [11:0] STICK_MAX_RST           = 12'd2000;
    localparam logic [15:0] HOLD_TIME_MS_RST        = 16'd2000;
    localparam logic [15:0] LOST_LIMIT_MS_RST       = 16'd10;
    localparam logic [7:0]  MODE_DEBOUNCE_TICKS_RST = 8'd10;
    localparam logic [15:0] LOW_BATTERY_MV_RST      = 16'd11100;

    // One input tick.
    typedef struct packed {
        logic [9:0]  elapsed_ms;
        logic [11:0] mode_channel;
        logic [11:0] throttle_channel;
        logic [11:0] yaw_channel;
        logic        failsafe_switch_down;
        logic        link_connected;
        logic [15:0] battery_mv;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic armed;
        logic signal_lost;
        logic low_battery;
        logic altitude_mode;
        logic blink_slow;
        logic led_force_off;
    } out_item_t;

    // Configuration register set.
    typedef struct packed {
        logic [11:0] mode_dead_threshold;
        logic [11:0] stick_min;
        logic [11:0] stick_max;
        logic [15:0] hold_time_ms;
        logic [15:0] lost_limit_ms;
        logic [7:0]  mode_debounce_ticks;
        logic [15:0] low_battery_mv;
    } cfg_t;

    // Supervisor state carried from tick to tick.
    typedef struct packed {
        logic [15:0] lost_time;
        logic        lost_flag;
        logic [7:0]  mode_count;
        logic        mode_is_alt;
        logic        locked_flag;
        logic [15:0] lock_time;
        logic [15:0] unlock_time;
    } sup_state_t;

    // Sixteen-bit saturating add of a millisecond count.
    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [9:0] b);
        logic [16:0] sum;
        begin
            sum = {1'b0, a} + {7'b0, b};
            sat_add16 = sum[16] ? 16'hFFFF : sum[15:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/afs_tick_logic.sv =====
`default_nettype none

// Next-state and result logic for one tick.
module afs_tick_logic (
    input  wire afs_pkg::cfg_t       cfg,
    input  wire afs_pkg::sup_state_t cur,
    input  wire afs_pkg::in_item_t   item,
    output afs_pkg::sup_state_t      nxt,
    output afs_pkg::out_item_t       result
);

    logic        link_bad;
    logic [15:0] lost_sum;
    logic        lost_next;
    logic        want_alt;
    logic [12:0] thr_limit;
    logic [12:0] yaw_limit;
    logic        yaw_ok;
    logic        gesture;
    logic [15:0] unlock_sum;
    logic [15:0] lock_sum;
    logic        low;

    // Signal-lost detection with a saturating bad-link timer.
    always_comb
    begin
        nxt      = cur;
        link_bad = item.failsafe_switch_down || !item.link_connected;
        lost_sum = afs_pkg::sat_add16(cur.lost_time, item.elapsed_ms);
        if (link_bad)
        begin
            if (lost_sum > cfg.lost_limit_ms)
            begin
                nxt.lost_flag = 1'b1;
                nxt.lost_time = cfg.lost_limit_ms;
            end
            else
            begin
                nxt.lost_time = lost_sum;
            end
        end
        else
        begin
            nxt.lost_flag = 1'b0;
            nxt.lost_time = 16'd0;
        end
        lost_next = nxt.lost_flag;

        // Flight-mode debounce; the count clears only on a switch.
        want_alt = !(item.mode_channel < cfg.mode_dead_threshold);
        if (want_alt != cur.mode_is_alt)
        begin
            if (cur.mode_count > cfg.mode_debounce_ticks)
            begin
                nxt.mode_is_alt = want_alt;
                nxt.mode_count  = 8'd0;
            end
            else if (cur.mode_count != 8'hFF)
            begin
                nxt.mode_count = cur.mode_count + 8'd1;
            end
        end

        // Stick gesture: throttle low and yaw high. A yaw limit below zero always passes.
        thr_limit = {1'b0, cfg.stick_min} + 13'(afs_pkg::GestureMargin);
        yaw_limit = {1'b0, cfg.stick_max} - 13'(afs_pkg::GestureMargin);
        yaw_ok    = ({1'b0, cfg.stick_max} < 13'(afs_pkg::GestureMargin)) ||
                    ({1'b0, item.yaw_channel} > yaw_limit);
        gesture   = ({1'b0, item.throttle_channel} < thr_limit) && yaw_ok;

        // Arm/disarm machine; signal loss forces the locked state.
        unlock_sum = afs_pkg::sat_add16(cur.unlock_time, item.elapsed_ms);
        lock_sum   = afs_pkg::sat_add16(cur.lock_time, item.elapsed_ms);
        if (cur.locked_flag)
        begin
            nxt.lock_time = 16'd0;
            if (gesture && !lost_next)
            begin
                nxt.unlock_time = unlock_sum;
                if (unlock_sum > cfg.hold_time_ms)
                begin
                    nxt.locked_flag = 1'b0;
                end
            end
            else
            begin
                nxt.unlock_time = 16'd0;
            end
        end
        else if (lost_next)
        begin
            nxt.locked_flag = 1'b1;
        end
        else
        begin
            nxt.unlock_time = 16'd0;
            nxt.lock_time   = gesture ? lock_sum : 16'd0;
            if (gesture && (lock_sum > cfg.hold_time_ms))
            begin
                nxt.locked_flag = 1'b1;
            end
        end

        // Battery check and result.
        low                  = item.battery_mv < cfg.low_battery_mv;
        result.armed         = !nxt.locked_flag;
        result.signal_lost   = nxt.lost_flag;
        result.low_battery   = low;
        result.altitude_mode = nxt.mode_is_alt;
        result.blink_slow    = nxt.locked_flag;
        result.led_force_off = low;
    end

endmodule

`default_nettype wire

// ===== rtl/arming_failsafe_supervisor_core.sv =====
`default_nettype none

// Arming and failsafe supervisor. Each input transfer is one control tick and
// yields exactly one result transfer. A tick is taken in every cycle in which
// in_valid is high and in_stall is low: the state update and result are
// computed in one pass from the incoming tick and the stored state, and the
// result is captured in an output register on the input transfer. in_stall
// rises only while that output register holds a result that the downstream
// side is stalling, so with no output stall the block sustains one tick per
// cycle. Configuration writes are always ready and take effect from the next
// tick; writes to indexes past the last register are dropped.
module arming_failsafe_supervisor_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire afs_pkg::in_item_t in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output afs_pkg::out_item_t   out_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [2:0]            cfg_index,
    input  wire [15:0]           cfg_data
);

    afs_pkg::cfg_t       cfg_reg;
    afs_pkg::sup_state_t state_reg;
    afs_pkg::sup_state_t state_next;
    afs_pkg::out_item_t  result_next;
    afs_pkg::out_item_t  out_data_reg;
    logic                out_valid_reg;
    logic                in_xfer;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_dead_threshold <= afs_pkg::MODE_DEAD_THRESHOLD_RST;
            cfg_reg.stick_min           <= afs_pkg::STICK_MIN_RST;
            cfg_reg.stick_max           <= afs_pkg::STICK_MAX_RST;
            cfg_reg.hold_time_ms        <= afs_pkg::HOLD_TIME_MS_RST;
            cfg_reg.lost_limit_ms       <= afs_pkg::LOST_LIMIT_MS_RST;
            cfg_reg.mode_debounce_ticks <= afs_pkg::MODE_DEBOUNCE_TICKS_RST;
            cfg_reg.low_battery_mv      <= afs_pkg::LOW_BATTERY_MV_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                afs_pkg::REG_MODE_DEAD_THRESHOLD: cfg_reg.mode_dead_threshold <= cfg_data[11:0];
                afs_pkg::REG_STICK_MIN:           cfg_reg.stick_min           <= cfg_data[11:0];
                afs_pkg::REG_STICK_MAX:           cfg_reg.stick_max           <= cfg_data[11:0];
                afs_pkg::REG_HOLD_TIME_MS:        cfg_reg.hold_time_ms        <= cfg_data;
                afs_pkg::REG_LOST_LIMIT_MS:       cfg_reg.lost_limit_ms       <= cfg_data;
                afs_pkg::REG_MODE_DEBOUNCE_TICKS: cfg_reg.mode_debounce_ticks <= cfg_data[7:0];
                afs_pkg::REG_LOW_BATTERY_MV:      cfg_reg.low_battery_mv      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Per-tick update logic.
    afs_tick_logic u_tick (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .item   (in_data),
        .nxt    (state_next),
        .result (result_next)
    );

    // Supervisor state advances on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.lost_time   <= 16'd0;
            state_reg.lost_flag   <= 1'b0;
            state_reg.mode_count  <= 8'd0;
            state_reg.mode_is_alt <= 1'b0;
            state_reg.locked_flag <= 1'b1;
            state_reg.lock_time   <= 16'd0;
            state_reg.unlock_time <= 16'd0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Output register: valid tracks pending results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload loads with each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= result_next;
        end
    end

endmodule

`default_nettype wire
